### rtl/bfm_pkg.sv
// Shared constants, types and helpers for the Murmur3 Bloom filter core.
package bfm_pkg;

  localparam int MAX_BITS_DEF   = 1048576;
  localparam int HASH_COUNT_DEF = 7;
  localparam int CFG_W          = 21;
  localparam logic [CFG_W-1:0] BIT_COUNT_RST = 21'd1048576;

  localparam logic [31:0] MM_C1  = 32'hcc9e2d51;
  localparam logic [31:0] MM_C2  = 32'h1b873593;
  localparam logic [31:0] MM_ADD = 32'he6546b64;
  localparam logic [31:0] MM_F1  = 32'h85ebca6b;
  localparam logic [31:0] MM_F2  = 32'hc2b2ae35;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_K1, ST_K2, ST_K3, ST_MIX, ST_F0, ST_F1,
    ST_F2, ST_DIV, ST_RD, ST_WR, ST_DONE
  } state_t;

  typedef enum logic [3:0] {
    DP_NOP, DP_CLEAR, DP_TAKE, DP_K1, DP_K2, DP_K3, DP_MIX, DP_F0,
    DP_F1, DP_F2, DP_DIV, DP_RD, DP_WR, DP_RESULT, DP_RESTART
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } cmd_t;

  typedef struct packed {
    logic take_go;    // accepted byte fills a block or ends the key
    logic blk_full;
    logic key_last;
    logic key_op;
    logic hash_last;
    logic div_done;
    logic clr_done;
    logic out_free;
  } status_t;

  function automatic logic [31:0] rotl32(input logic [31:0] x, input int r);
    rotl32 = (x << r) | (x >> (32 - r));
  endfunction

endpackage

### rtl/bfm_key_if.sv
// Key byte channel: one byte per transaction with last and empty-key marks.
interface bfm_key_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] key_byte;
  logic       has_byte;
  logic       last;
  modport source (output valid, op, key_byte, has_byte, last, input ready);
  modport sink   (input valid, op, key_byte, has_byte, last, output ready);
endinterface

### rtl/bfm_result_if.sv
// Query result channel.
interface bfm_result_if;
  logic valid;
  logic ready;
  logic found;
  modport source (output valid, found, input ready);
  modport sink   (input valid, found, output ready);
endinterface

### rtl/bfm_ctrl.sv
// Sequencer for the Bloom filter: clearing, hashing, reduction and bit access.
module bfm_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             key_valid,
  output logic             key_ready,
  input  bfm_pkg::status_t st,
  output bfm_pkg::cmd_t    cmd
);
  import bfm_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    key_ready  = 1'b0;
    cmd.op     = DP_NOP;
    case (state)
      ST_CLEAR: begin
        cmd.op = DP_CLEAR;
        if (st.clr_done) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        key_ready = 1'b1;
        if (key_valid) begin
          cmd.op = DP_TAKE;
          if (st.take_go) state_next = ST_K1;
        end
      end
      ST_K1: begin
        cmd.op = DP_K1;
        state_next = ST_K2;
      end
      ST_K2: begin
        cmd.op = DP_K2;
        state_next = ST_K3;
      end
      ST_K3: begin
        cmd.op = DP_K3;
        state_next = st.blk_full ? ST_MIX : ST_F0;
      end
      ST_MIX: begin
        cmd.op = DP_MIX;
        if (st.hash_last) state_next = st.key_last ? ST_K1 : ST_IDLE;
      end
      ST_F0: begin
        cmd.op = DP_F0;
        state_next = ST_F1;
      end
      ST_F1: begin
        cmd.op = DP_F1;
        state_next = ST_F2;
      end
      ST_F2: begin
        cmd.op = DP_F2;
        state_next = ST_DIV;
      end
      ST_DIV: begin
        cmd.op = DP_DIV;
        if (st.div_done) state_next = ST_RD;
      end
      ST_RD: begin
        cmd.op = DP_RD;
        state_next = ST_WR;
      end
      ST_WR: begin
        cmd.op = DP_WR;
        state_next = st.hash_last ? ST_DONE : ST_F0;
      end
      ST_DONE: begin
        if (st.key_op) begin
          cmd.op = DP_RESTART;
          state_next = ST_IDLE;
        end else if (st.out_free) begin
          cmd.op = DP_RESULT;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

### rtl/bfm_dp.sv
// Datapath: key accumulators, shared multiplier, bit-serial modulo, filter memory.
module bfm_dp #(
  parameter int MAX_BITS   = bfm_pkg::MAX_BITS_DEF,
  parameter int HASH_COUNT = bfm_pkg::HASH_COUNT_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  bfm_pkg::cmd_t            cmd,
  output bfm_pkg::status_t         st,
  input  logic                     in_op,
  input  logic [7:0]               in_key_byte,
  input  logic                     in_has_byte,
  input  logic                     in_last,
  input  logic                     cfg_we,
  input  logic [bfm_pkg::CFG_W-1:0] cfg_wdata,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic                     out_found
);
  import bfm_pkg::*;

  localparam int ROWS = (MAX_BITS + 7) / 8;
  localparam int AW   = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int RW   = $clog2(MAX_BITS + 1);
  localparam int HW   = (HASH_COUNT > 1) ? $clog2(HASH_COUNT) : 1;

  logic [31:0]      acc [HASH_COUNT];
  logic [31:0]      tail, len, k, mreg, quot;
  logic [RW-1:0]    rem, modv;
  logic [4:0]       divcnt;
  logic [HW-1:0]    hidx;
  logic [7:0]       rdata;
  logic [AW-1:0]    clr_addr;
  logic [CFG_W-1:0] bit_count;
  logic             all_set, key_op, key_last, blk_full;

  logic [7:0]       mem [ROWS];

  logic [31:0]      acc_sel, mix_x, h0, h1, t1;
  logic [RW:0]      sh, diff;
  logic [RW-1:0]    modv_eff;
  logic [AW-1:0]    addr;
  logic [7:0]       bmask;

  assign acc_sel = acc[hidx];
  assign mix_x   = rotl32(acc_sel ^ k, 13);
  assign h0      = acc_sel ^ ((len[1:0] != 2'd0) ? k : 32'd0) ^ len;
  assign h1      = h0 ^ (h0 >> 16);
  assign t1      = mreg ^ (mreg >> 13);
  assign sh      = {rem, quot[31]};
  assign diff    = sh - {1'b0, modv};
  assign addr    = AW'(rem >> 3);
  assign bmask   = 8'd1 << rem[2:0];

  always_comb begin
    if (bit_count == '0) begin
      modv_eff = RW'(1);
    end else if ({11'd0, bit_count} > 32'(MAX_BITS)) begin
      modv_eff = RW'(MAX_BITS);
    end else begin
      modv_eff = RW'(bit_count);
    end
  end

  always_comb begin
    st.take_go   = (in_has_byte && (len[1:0] == 2'd3)) || in_last;
    st.blk_full  = blk_full;
    st.key_last  = key_last;
    st.key_op    = key_op;
    st.hash_last = (hidx == HW'(HASH_COUNT - 1));
    st.div_done  = (divcnt == 5'd31);
    st.clr_done  = (clr_addr == AW'(ROWS - 1));
    st.out_free  = !out_valid || out_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_count <= BIT_COUNT_RST;
    end else if (cfg_we) begin
      bit_count <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.op == DP_RESULT || cmd.op == DP_RESTART) begin
      for (int i = 0; i < HASH_COUNT; i++) acc[i] <= 32'(i);
      tail     <= '0;
      len      <= '0;
      hidx     <= '0;
      all_set  <= 1'b1;
      blk_full <= 1'b0;
      key_last <= 1'b0;
      key_op   <= 1'b0;
    end else begin
      case (cmd.op)
        DP_TAKE: begin
          if (in_has_byte) begin
            tail <= tail | ({24'd0, in_key_byte} << {len[1:0], 3'b000});
            len  <= len + 32'd1;
          end
          blk_full <= in_has_byte && (len[1:0] == 2'd3);
          key_last <= in_last;
          key_op   <= in_op;
        end
        DP_K3: k <= mreg;
        DP_MIX: begin
          acc[hidx] <= (mix_x << 2) + mix_x + MM_ADD;
          if (hidx == HW'(HASH_COUNT - 1)) begin
            hidx     <= '0;
            tail     <= '0;
            blk_full <= 1'b0;
          end else begin
            hidx <= hidx + HW'(1);
          end
        end
        DP_WR: begin
          if (!key_op && (rdata & bmask) == 8'd0) all_set <= 1'b0;
          if (hidx == HW'(HASH_COUNT - 1)) hidx <= '0;
          else hidx <= hidx + HW'(1);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      DP_K1: mreg <= tail * MM_C1;
      DP_K2: mreg <= rotl32(mreg, 15) * MM_C2;
      DP_F0: mreg <= h1 * MM_F1;
      DP_F1: mreg <= t1 * MM_F2;
      DP_F2: begin
        quot   <= mreg ^ (mreg >> 16);
        rem    <= '0;
        modv   <= modv_eff;
        divcnt <= '0;
      end
      DP_DIV: begin
        rem    <= (sh >= {1'b0, modv}) ? diff[RW-1:0] : sh[RW-1:0];
        quot   <= quot << 1;
        divcnt <= divcnt + 5'd1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.op == DP_CLEAR) begin
      clr_addr <= clr_addr + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == DP_CLEAR) begin
      mem[clr_addr] <= 8'd0;
    end else if (cmd.op == DP_WR && key_op) begin
      mem[addr] <= rdata | bmask;
    end
    if (cmd.op == DP_RD) begin
      rdata <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.op == DP_RESULT) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == DP_RESULT) begin
      out_found <= all_set;
    end
  end

endmodule

### rtl/bloom_filter_murmur3_core.sv
// Top level of the Bloom filter core with HASH_COUNT (default seven) Murmur3 x86_32 hashes.
//
//   channel     dir  handshake        payload
//   key_in      in   valid/ready      op, key_byte, has_byte, last
//   result_out  out  valid/ready      found
//   cfg         in   cfg_we           cfg_wdata (bit_count)
//
// A byte that does not finish a block is taken in ST_IDLE; a full block adds K1, K2, K3
// and one MIX per hash. A finished key adds per hash the F0-F2 multiply/mix steps, a
// bit-serial modulo and a read and a write, with one shared modulo unit and memory port.
// After reset a clearing pass zeroes all (MAX_BITS + 7) / 8 rows with key_in not ready.
// A waiting result does not block new bytes; only the next query result waits for it.
module bloom_filter_murmur3_core #(
  parameter int MAX_BITS   = bfm_pkg::MAX_BITS_DEF,
  parameter int HASH_COUNT = bfm_pkg::HASH_COUNT_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  bfm_key_if.sink                   key_in,
  bfm_result_if.source              result_out,
  input  logic                      cfg_we,
  input  logic [bfm_pkg::CFG_W-1:0] cfg_wdata
);
  import bfm_pkg::*;

  cmd_t    cmd;
  status_t st;

  bfm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .key_valid (key_in.valid),
    .key_ready (key_in.ready),
    .st        (st),
    .cmd       (cmd)
  );

  bfm_dp #(
    .MAX_BITS   (MAX_BITS),
    .HASH_COUNT (HASH_COUNT)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .st          (st),
    .in_op       (key_in.op),
    .in_key_byte (key_in.key_byte),
    .in_has_byte (key_in.has_byte),
    .in_last     (key_in.last),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .out_valid   (result_out.valid),
    .out_ready   (result_out.ready),
    .out_found   (result_out.found)
  );

endmodule
